// File: sv/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/rrdc_pkg.sv
package rrdc_pkg;

	// Header and frame limits.
	localparam int MAX_FRAME = 1518;
	localparam int HDR_BYTES = 4;
	localparam logic [15:0] MIN_COUNT = 16'd64;
	localparam logic [15:0] MAX_COUNT = 16'(MAX_FRAME + HDR_BYTES);
	localparam logic [7:0] STATUS_OK = 8'h01;
	localparam int PAGE_SHIFT = 8;

	// Register reset values.
	localparam logic        DEVICE_PRESENT_RST = 1'b0;
	localparam logic [7:0]  RING_START_RST     = 8'd70;
	localparam logic [7:0]  RING_STOP_RST      = 8'd128;
	localparam logic [10:0] BUFFER_LIMIT_RST   = 11'd1518;

	// Configuration register indexes (byte address / 4).
	typedef enum logic [1:0] {
		REG_DEVICE_PRESENT = 2'd0,
		REG_RING_START     = 2'd1,
		REG_RING_STOP      = 2'd2,
		REG_BUFFER_LIMIT   = 2'd3
	} reg_idx_t;

	// Outcome codes reported with every result item.
	typedef enum logic [2:0] {
		OUT_NOTHING  = 3'd0,
		OUT_FRAME_OK = 3'd1,
		OUT_OVERFLOW = 3'd2,
		OUT_CORRUPT  = 3'd3,
		OUT_SKIPPED  = 3'd4
	} outcome_t;

endpackage

// File: sv/rrdc_if.sv
// One receive attempt: write page, overflow flag and the header at the next page.
interface rrdc_attempt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  write_page;
	logic        overflow_pending;
	logic [7:0]  hdr_status;
	logic [7:0]  hdr_next_page;
	logic [15:0] hdr_count;

	modport source (
		output valid, write_page, overflow_pending, hdr_status, hdr_next_page, hdr_count,
		input  ready
	);
	modport sink (
		input  valid, write_page, overflow_pending, hdr_status, hdr_next_page, hdr_count,
		output ready
	);
endinterface

// One decision: outcome, read plan for a good frame and the updated state.
interface rrdc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  outcome;
	logic [15:0] first_addr;
	logic [10:0] first_len;
	logic [10:0] second_len;
	logic [10:0] frame_len;
	logic [7:0]  new_boundary;
	logic        ring_restart;
	logic [31:0] overflow_total;

	modport source (
		output valid, outcome, first_addr, first_len, second_len, frame_len,
		       new_boundary, ring_restart, overflow_total,
		input  ready
	);
	modport sink (
		input  valid, outcome, first_addr, first_len, second_len, frame_len,
		       new_boundary, ring_restart, overflow_total,
		output ready
	);
endinterface

// File: sv/rx_ring_dequeue_control_unit.sv
// Receive ring dequeue control. Each item on the attempt channel is one receive
// attempt: the page the receiver writes next, an overflow flag and the 4-byte
// header read at the page after the boundary. For each attempt exactly one item
// leaves on the result channel with the outcome, the card address and the two
// read lengths of a good frame (split at the ring end), the new boundary page,
// a ring restart flag and the running overflow count.
// Both channels use valid/ready; the four registers sit behind an APB port at
// byte addresses 0, 4, 8 and 12. The user must see that they are written only
// while the block is idle; the block does not enforce this. An accepted item
// lands in the input stage, the decision is made there against the boundary
// register and is loaded into the result stage together with the state update.
// Throughput is one item per cycle while results are taken; the boundary and
// overflow count change as the item retires; the next item sees them at once.
// If the receiver stalls, the result stage holds and the input stage can still
// take one more item; after that ready drops until the result is taken.
// Reset clears both stages, sets the registers to their defaults and loads the
// boundary with the default ring start and the overflow count with zero.

`include "assert_macros.svh"

module rx_ring_dequeue_control_unit (
	input  logic                clk,
	input  logic                arst_n,
	rrdc_attempt_if.sink        attempt,
	rrdc_result_if.source       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import rrdc_pkg::*;

	// Configuration registers.
	logic        device_present_q;
	logic [7:0]  ring_start_q;
	logic [7:0]  ring_stop_q;
	logic [10:0] buffer_limit_q;

	// Block state.
	logic [7:0]  boundary_q;
	logic [31:0] overflow_count_q;

	// Input stage.
	logic        valid_s1;
	logic [7:0]  write_page_s1;
	logic        overflow_pending_s1;
	logic [7:0]  hdr_status_s1;
	logic [7:0]  hdr_next_page_s1;
	logic [15:0] hdr_count_s1;

	// Result stage.
	logic        valid_s2;
	outcome_t    outcome_s2;
	logic [15:0] first_addr_s2;
	logic [10:0] first_len_s2;
	logic [10:0] second_len_s2;
	logic [10:0] frame_len_s2;
	logic [7:0]  new_boundary_s2;
	logic        ring_restart_s2;
	logic [31:0] overflow_total_s2;

	logic        advance;
	logic        accept;
	logic        cfg_write;
	reg_idx_t    cfg_idx;

	// Decision logic.
	logic [7:0]  next_inc;
	logic [7:0]  next_page;
	logic        ring_empty;
	logic        hdr_corrupt;
	logic [7:0]  adv_boundary;
	logic [10:0] payload_len;
	logic [10:0] clamped_len;
	logic [15:0] data_addr;
	logic [15:0] ring_end;
	logic [15:0] room;
	logic [10:0] len1;
	logic [10:0] len2;

	outcome_t    nx_outcome;
	logic [15:0] nx_addr;
	logic [10:0] nx_len1;
	logic [10:0] nx_len2;
	logic [10:0] nx_flen;
	logic [7:0]  nx_boundary;
	logic        nx_restart;
	logic [31:0] nx_ovf_count;

	// The result stage moves when it is empty or being taken; the input stage
	// takes a new item when it is empty or its contents can move on.
	assign advance         = !valid_s2 || result.ready;
	assign attempt.ready   = !valid_s1 || advance;
	assign accept          = attempt.valid && attempt.ready;

	// APB: no wait states, the write lands in the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_DEVICE_PRESENT: prdata = {31'd0, device_present_q};
			REG_RING_START:     prdata = {24'd0, ring_start_q};
			REG_RING_STOP:      prdata = {24'd0, ring_stop_q};
			REG_BUFFER_LIMIT:   prdata = {21'd0, buffer_limit_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_present_q <= DEVICE_PRESENT_RST;
			ring_start_q     <= RING_START_RST;
			ring_stop_q      <= RING_STOP_RST;
			buffer_limit_q   <= BUFFER_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_DEVICE_PRESENT: device_present_q <= pwdata[0];
				REG_RING_START:     ring_start_q     <= pwdata[7:0];
				REG_RING_STOP:      ring_stop_q      <= pwdata[7:0];
				REG_BUFFER_LIMIT:   buffer_limit_q   <= pwdata[10:0];
			endcase
		end
	end

	// The page after the boundary, wrapping back to the ring start at the stop page.
	assign next_inc   = boundary_q + 8'd1;
	assign next_page  = (next_inc >= ring_stop_q) ? ring_start_q : next_inc;
	assign ring_empty = (next_page == write_page_s1);

	assign hdr_corrupt = (hdr_next_page_s1 < ring_start_q) ||
	                     (hdr_next_page_s1 >= ring_stop_q) ||
	                     (hdr_count_s1 < MIN_COUNT) ||
	                     (hdr_count_s1 > MAX_COUNT);

	// The boundary trails the link by one page; a link at the ring start wraps
	// the boundary to the last page of the ring.
	assign adv_boundary = (hdr_next_page_s1 == ring_start_q) ?
	                      (ring_stop_q - 8'd1) : (hdr_next_page_s1 - 8'd1);

	// A header that is not corrupt has a count below 2048, so the low 11 bits
	// carry the whole length.
	assign payload_len = hdr_count_s1[10:0] - 11'(HDR_BYTES);
	assign clamped_len = (payload_len > buffer_limit_q) ? buffer_limit_q : payload_len;

	// Split the read at the ring end; a negative room means everything wraps.
	assign data_addr = {next_page, 8'(HDR_BYTES)};
	assign ring_end  = {ring_stop_q, 8'd0};
	assign room      = (ring_end > data_addr) ? (ring_end - data_addr) : 16'd0;
	assign len1      = (room < {5'd0, clamped_len}) ? room[10:0] : clamped_len;
	assign len2      = clamped_len - len1;

	always_comb begin
		nx_outcome   = OUT_NOTHING;
		nx_addr      = 16'd0;
		nx_len1      = 11'd0;
		nx_len2      = 11'd0;
		nx_flen      = 11'd0;
		nx_boundary  = boundary_q;
		nx_restart   = 1'b0;
		nx_ovf_count = overflow_count_q;
		priority if (!device_present_q) begin
			nx_outcome = OUT_NOTHING;
		end else if (overflow_pending_s1) begin
			nx_outcome   = OUT_OVERFLOW;
			nx_ovf_count = overflow_count_q + 32'd1;
			nx_boundary  = ring_start_q;
			nx_restart   = 1'b1;
		end else if (ring_empty) begin
			nx_outcome = OUT_NOTHING;
		end else if (hdr_corrupt) begin
			nx_outcome  = OUT_CORRUPT;
			nx_boundary = ring_start_q;
			nx_restart  = 1'b1;
		end else if ((hdr_status_s1 & STATUS_OK) == 8'd0) begin
			nx_outcome  = OUT_SKIPPED;
			nx_boundary = adv_boundary;
		end else begin
			nx_outcome  = OUT_FRAME_OK;
			nx_addr     = data_addr;
			nx_len1     = len1;
			nx_len2     = len2;
			nx_flen     = clamped_len;
			nx_boundary = adv_boundary;
		end
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			boundary_q       <= RING_START_RST;
			overflow_count_q <= 32'd0;
		end else begin
			if (attempt.ready) begin
				valid_s1 <= attempt.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					boundary_q       <= nx_boundary;
					overflow_count_q <= nx_ovf_count;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			write_page_s1       <= attempt.write_page;
			overflow_pending_s1 <= attempt.overflow_pending;
			hdr_status_s1       <= attempt.hdr_status;
			hdr_next_page_s1    <= attempt.hdr_next_page;
			hdr_count_s1        <= attempt.hdr_count;
		end
		if (advance && valid_s1) begin
			outcome_s2        <= nx_outcome;
			first_addr_s2     <= nx_addr;
			first_len_s2      <= nx_len1;
			second_len_s2     <= nx_len2;
			frame_len_s2      <= nx_flen;
			new_boundary_s2   <= nx_boundary;
			ring_restart_s2   <= nx_restart;
			overflow_total_s2 <= nx_ovf_count;
		end
	end

	assign result.valid          = valid_s2;
	assign result.outcome        = outcome_s2;
	assign result.first_addr     = first_addr_s2;
	assign result.first_len      = first_len_s2;
	assign result.second_len     = second_len_s2;
	assign result.frame_len      = frame_len_s2;
	assign result.new_boundary   = new_boundary_s2;
	assign result.ring_restart   = ring_restart_s2;
	assign result.overflow_total = overflow_total_s2;

	// The two reads of a good frame always add up to the delivered length.
	`ASSERT_IMPLIES(a_split_sums, clk, arst_n,
		valid_s2 && (outcome_s2 == OUT_FRAME_OK),
		(first_len_s2 + second_len_s2) == frame_len_s2)

	// A restart is requested exactly on overflow and corrupt-ring outcomes.
	`ASSERT_IMPLIES(a_restart_outcome, clk, arst_n,
		valid_s2,
		ring_restart_s2 == ((outcome_s2 == OUT_OVERFLOW) || (outcome_s2 == OUT_CORRUPT)))

	// The overflow count only moves when an overflow result is being loaded.
	`ASSERT_NEXT(a_ovf_count_moves, clk, arst_n,
		!(advance && valid_s1 && device_present_q && overflow_pending_s1),
		$stable(overflow_count_q))

	// The reported boundary is the state left behind by that item.
	`ASSERT_NEXT(a_boundary_tracks, clk, arst_n,
		advance && valid_s1,
		new_boundary_s2 == boundary_q)

	// With the result stage empty the block never refuses an attempt.
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n,
		!valid_s2,
		attempt.ready)

endmodule

// File: verif/rx_ring_dequeue_control_unit_tb.sv
`timescale 1ns / 100ps

module rx_ring_dequeue_control_unit_tb;
	import rrdc_pkg::*;

	// One receive attempt as it goes onto the attempt channel.
	typedef struct packed {
		logic [7:0]  write_page;
		logic        overflow_pending;
		logic [7:0]  hdr_status;
		logic [7:0]  hdr_next_page;
		logic [15:0] hdr_count;
	} attempt_t;

	// One decision as it leaves on the result channel.
	typedef struct packed {
		outcome_t    outcome;
		logic [15:0] first_addr;
		logic [10:0] first_len;
		logic [10:0] second_len;
		logic [10:0] frame_len;
		logic [7:0]  new_boundary;
		logic        ring_restart;
		logic [31:0] overflow_total;
	} decision_t;

	// One setting of the four registers for a random phase.
	typedef struct {
		logic        present;
		logic [7:0]  start;
		logic [7:0]  stop;
		logic [10:0] limit;
	} ring_setting_t;

	localparam int NUM_PHASES     = 10;
	localparam int PHASE_ATTEMPTS = 165;
	// The settle pause lets the input and result stages drain with margin to spare.
	localparam int SETTLE_CYCLES  = 6;
	// Cycles without any item moving on either channel before the run is declared hung.
	// Even with one side idling 73 percent of the time, a stretch this long is
	// practically impossible in a healthy run.
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;

	rrdc_attempt_if attempt_ch ();
	rrdc_result_if  result_ch ();

	rx_ring_dequeue_control_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.attempt (attempt_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the registers, updated when an APB write completes.
	logic        present_q = DEVICE_PRESENT_RST;
	logic [7:0]  start_q   = RING_START_RST;
	logic [7:0]  stop_q    = RING_STOP_RST;
	logic [10:0] limit_q   = BUFFER_LIMIT_RST;

	// Shadow copy of the block's state, advanced once per accepted attempt.
	logic [7:0]  boundary_q  = RING_START_RST;
	logic [31:0] overflows_q = '0;

	attempt_t  pending_attempts[$];
	decision_t expected_decisions[$];
	attempt_t  offered;
	decision_t want;
	decision_t got;

	int attempts_queued = 0;
	int attempts_taken  = 0;
	int results_seen    = 0;
	int errors          = 0;
	int quiet_cycles    = 0;
	int idle_pct        = 0;
	int stall_pct       = 0;

	// Boundary after a frame is consumed: one page behind the link, except that a
	// link back to the ring start puts the boundary on the last page of the ring.
	function automatic logic [7:0] boundary_after(input logic [7:0] link);
		if (link == start_q)
			return stop_q - 8'd1;
		return link - 8'd1;
	endfunction

	// Decides one attempt against the shadow registers and state, and updates
	// the shadow state the way the block must.
	function automatic decision_t decide_attempt(input attempt_t a);
		decision_t   d;
		logic [7:0]  next_page;
		int unsigned ring_end;
		int unsigned addr;
		int unsigned room;
		int unsigned flen;
		int unsigned len1;
		d = '0;
		d.outcome = OUT_NOTHING;
		if (!present_q) begin
			// No card: the attempt is reported as nothing and the state holds.
		end else if (a.overflow_pending) begin
			// Overflow recovery drops whatever the header says.
			overflows_q  = overflows_q + 32'd1;
			boundary_q   = start_q;
			d.ring_restart = 1'b1;
			d.outcome    = OUT_OVERFLOW;
		end else begin
			next_page = boundary_q + 8'd1;
			if (next_page >= stop_q)
				next_page = start_q;
			if (next_page == a.write_page) begin
				// The ring is empty; nothing to dequeue.
			end else if (a.hdr_next_page < start_q || a.hdr_next_page >= stop_q ||
					a.hdr_count < MIN_COUNT || a.hdr_count > MAX_COUNT) begin
				boundary_q     = start_q;
				d.ring_restart = 1'b1;
				d.outcome      = OUT_CORRUPT;
			end else if ((a.hdr_status & STATUS_OK) == 8'h00) begin
				boundary_q = boundary_after(a.hdr_next_page);
				d.outcome  = OUT_SKIPPED;
			end else begin
				flen = int'(a.hdr_count) - HDR_BYTES;
				if (flen > int'(limit_q))
					flen = int'(limit_q);
				addr     = (int'(next_page) << PAGE_SHIFT) + HDR_BYTES;
				ring_end = int'(stop_q) << PAGE_SHIFT;
				// With a misconfigured ring the room is negative; it counts as none.
				room = (ring_end > addr) ? ring_end - addr : 0;
				len1 = (room < flen) ? room : flen;
				d.first_addr = addr[15:0];
				d.first_len  = len1[10:0];
				d.second_len = 11'(flen - len1);
				d.frame_len  = flen[10:0];
				boundary_q   = boundary_after(a.hdr_next_page);
				d.outcome    = OUT_FRAME_OK;
			end
		end
		d.new_boundary   = boundary_q;
		d.overflow_total = overflows_q;
		return d;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			errors++;
		end
	endfunction

	function automatic attempt_t attempt_of(input logic [7:0] wp, input logic ovf,
			input logic [7:0] status, input logic [7:0] link, input logic [15:0] count);
		attempt_t a;
		a.write_page       = wp;
		a.overflow_pending = ovf;
		a.hdr_status       = status;
		a.hdr_next_page    = link;
		a.hdr_count        = count;
		return a;
	endfunction

	// Most random attempts carry a header that is plausible for the current ring,
	// so that the stimulus gets past the corrupt check and exercises frame
	// delivery, skipping and the split at the ring end. The rest is overflow and
	// fully random noise, which also toggles every bit of every field.
	function automatic attempt_t random_attempt();
		attempt_t a;
		int unsigned pick;
		pick = $urandom_range(99);
		a.write_page       = 8'($urandom_range(255));
		a.overflow_pending = 1'b0;
		a.hdr_status       = 8'($urandom_range(255));
		a.hdr_next_page    = 8'($urandom_range(255));
		a.hdr_count        = 16'($urandom_range(65535));
		if (pick < 6) begin
			a.overflow_pending = 1'b1;
		end else if (pick < 20) begin
			a.overflow_pending = 1'($urandom_range(1));
		end else begin
			if (stop_q > start_q) begin
				a.hdr_next_page = 8'(start_q + $urandom_range(stop_q - start_q - 1));
				// Now and then the write page sits inside the ring so that it
				// can catch up with the boundary and show an empty ring.
				if ($urandom_range(9) == 0)
					a.write_page = 8'(start_q + $urandom_range(stop_q - start_q - 1));
			end
			a.hdr_count = 16'($urandom_range(int'(MAX_COUNT), int'(MIN_COUNT)));
			if ($urandom_range(99) < 85)
				a.hdr_status = a.hdr_status | STATUS_OK;
			else
				a.hdr_status = a.hdr_status & ~STATUS_OK;
		end
		return a;
	endfunction

	task automatic queue_attempt(input attempt_t a);
		pending_attempts.push_back(a);
		attempts_queued++;
	endtask

	// A write has a setup phase and an access phase; pready is always high,
	// so the register is written at the edge that ends the access phase.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DEVICE_PRESENT: present_q = value[0];
			REG_RING_START:     start_q   = value[7:0];
			REG_RING_STOP:      stop_q    = value[7:0];
			REG_BUFFER_LIMIT:   limit_q   = value[10:0];
			default: ;
		endcase
	endtask

	// Waits until every queued attempt has been taken and every decision has
	// come back, then lets the pipeline settle before registers are touched.
	task automatic wait_idle();
		while (attempts_taken != attempts_queued || results_seen != attempts_taken)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 73; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 73; end
			default: begin idle_pct = 21; stall_pct = 21; end
		endcase
	endtask

	// Attempt driver. An accepted attempt is decided by the predictor in the same
	// edge, so the shadow state always follows the order in which the block
	// takes items. The next attempt is offered only once the current one is
	// gone; valid stays high across back-to-back items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_ch.valid <= 1'b0;
		end else begin
			if (attempt_ch.valid && attempt_ch.ready) begin
				expected_decisions.push_back(decide_attempt(offered));
				attempts_taken++;
			end
			if (!attempt_ch.valid || attempt_ch.ready) begin
				if (pending_attempts.size() > 0 && $urandom_range(99) >= idle_pct) begin
					offered = pending_attempts.pop_front();
					attempt_ch.valid            <= 1'b1;
					attempt_ch.write_page       <= offered.write_page;
					attempt_ch.overflow_pending <= offered.overflow_pending;
					attempt_ch.hdr_status       <= offered.hdr_status;
					attempt_ch.hdr_next_page    <= offered.hdr_next_page;
					attempt_ch.hdr_count        <= offered.hdr_count;
				end else begin
					// Idle: the payload carries junk that must be ignored.
					attempt_ch.valid            <= 1'b0;
					attempt_ch.write_page       <= 8'($urandom_range(255));
					attempt_ch.overflow_pending <= 1'($urandom_range(1));
					attempt_ch.hdr_status       <= 8'($urandom_range(255));
					attempt_ch.hdr_next_page    <= 8'($urandom_range(255));
					attempt_ch.hdr_count        <= 16'($urandom_range(65535));
				end
			end
		end
	end

	// Result monitor. Each accepted decision is compared with the oldest one the
	// predictor produced; ready is redrawn every cycle to stall the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_decisions.size() == 0) begin
					$error("result item arrived with no attempt outstanding");
					errors++;
				end else begin
					want = expected_decisions.pop_front();
					got.outcome        = outcome_t'(result_ch.outcome);
					got.first_addr     = result_ch.first_addr;
					got.first_len      = result_ch.first_len;
					got.second_len     = result_ch.second_len;
					got.frame_len      = result_ch.frame_len;
					got.new_boundary   = result_ch.new_boundary;
					got.ring_restart   = result_ch.ring_restart;
					got.overflow_total = result_ch.overflow_total;
					check_field("outcome", 32'(want.outcome), 32'(got.outcome));
					check_field("first_addr", 32'(want.first_addr), 32'(got.first_addr));
					check_field("first_len", 32'(want.first_len), 32'(got.first_len));
					check_field("second_len", 32'(want.second_len), 32'(got.second_len));
					check_field("frame_len", 32'(want.frame_len), 32'(got.frame_len));
					check_field("new_boundary", 32'(want.new_boundary),
						32'(got.new_boundary));
					check_field("ring_restart", 32'(want.ring_restart),
						32'(got.ring_restart));
					check_field("overflow_total", want.overflow_total, got.overflow_total);
				end
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Counts cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (attempt_ch.valid && attempt_ch.ready) ||
				(result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$error("no progress for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	ring_setting_t settings[NUM_PHASES];

	initial begin
		// Random phases: the reset ring, the widest ring with the largest limit, a zero
		// buffer limit, a small ring, a one-page ring, a ring at the top of the page
		// space, two misconfigured rings (stop of zero, start equal to stop), a mid-size
		// ring with the largest limit, and finally the card removed with other extremes.
		settings[0] = '{1'b1, 8'd70,  8'd128, 11'd1518};
		settings[1] = '{1'b1, 8'd0,   8'd255, 11'd2047};
		settings[2] = '{1'b1, 8'd64,  8'd96,  11'd0};
		settings[3] = '{1'b1, 8'd10,  8'd20,  11'd300};
		settings[4] = '{1'b1, 8'd0,   8'd1,   11'd1600};
		settings[5] = '{1'b1, 8'd254, 8'd255, 11'd64};
		settings[6] = '{1'b1, 8'd200, 8'd0,   11'd1000};
		settings[7] = '{1'b1, 8'd100, 8'd100, 11'd500};
		settings[8] = '{1'b1, 8'd32,  8'd128, 11'd2047};
		settings[9] = '{1'b0, 8'd255, 8'd0,   11'd0};

		arst_n                      = 1'b0;
		psel                        = 1'b0;
		penable                     = 1'b0;
		pwrite                      = 1'b0;
		paddr                       = '0;
		pwdata                      = '0;
		attempt_ch.valid            = 1'b0;
		attempt_ch.write_page       = '0;
		attempt_ch.overflow_pending = 1'b0;
		attempt_ch.hdr_status       = '0;
		attempt_ch.hdr_next_page    = '0;
		attempt_ch.hdr_count        = '0;
		result_ch.ready             = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the card is absent: even an overflow reports nothing and
		// the count stays at zero, while the boundary shows the default start.
		set_idling(3);
		queue_attempt(attempt_of(8'd0, 1'b1, 8'hFF, 8'd80, 16'd100));
		queue_attempt(attempt_of(8'd255, 1'b0, 8'h01, 8'd80, 16'd100));
		wait_idle();

		// Directed pass on the default ring (start 70, stop 128, limit 1518).
		apb_write(REG_DEVICE_PRESENT, 32'd1);
		set_idling(0);
		// Empty ring: the write page equals the next page.
		queue_attempt(attempt_of(8'd71, 1'b0, 8'h01, 8'd80, 16'd100));
		// Shortest good frame.
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd71, 16'd64));
		// Each way a header can be corrupt.
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd69, 16'd100));
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd128, 16'd100));
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd90, 16'd63));
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd90, 16'd1523));
		queue_attempt(attempt_of(8'd0, 1'b0, 8'hFF, 8'd255, 16'd65535));
		// Bad status skips the frame and moves the boundary to 99.
		queue_attempt(attempt_of(8'd0, 1'b0, 8'hFE, 8'd100, 16'd100));
		// Longest frame, no split; the boundary goes to 126.
		queue_attempt(attempt_of(8'd0, 1'b0, 8'hFF, 8'd127, 16'd1522));
		// Frame on the last page splits at the ring end; its link back to the
		// ring start puts the boundary on the last page.
		queue_attempt(attempt_of(8'd255, 1'b0, 8'h01, 8'd70, 16'd1522));
		// The next page wraps past the ring end to the ring start.
		queue_attempt(attempt_of(8'd255, 1'b0, 8'h01, 8'd80, 16'd1000));
		// Overflow, once with a clean header and once with a corrupt one.
		queue_attempt(attempt_of(8'd0, 1'b1, 8'h01, 8'd80, 16'd100));
		queue_attempt(attempt_of(8'd71, 1'b1, 8'h00, 8'd0, 16'd0));
		queue_attempt(attempt_of(8'd255, 1'b0, 8'h01, 8'd127, 16'd1522));
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd127, 16'd1100));
		wait_idle();

		// Zero buffer limit truncates every frame to nothing.
		apb_write(REG_BUFFER_LIMIT, 32'd0);
		set_idling(2);
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd100, 16'd1522));
		queue_attempt(attempt_of(8'd0, 1'b0, 8'h01, 8'd110, 16'd64));
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			apb_write(REG_DEVICE_PRESENT, {31'd0, settings[p].present});
			apb_write(REG_RING_START, {24'd0, settings[p].start});
			apb_write(REG_RING_STOP, {24'd0, settings[p].stop});
			apb_write(REG_BUFFER_LIMIT, {21'd0, settings[p].limit});
			set_idling(p % 4);
			for (int i = 0; i < PHASE_ATTEMPTS; i++)
				queue_attempt(random_attempt());
			wait_idle();
		end

		if (errors == 0 && expected_decisions.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/rrdc_pkg.sv
sv/rrdc_if.sv
sv/rx_ring_dequeue_control_unit.sv
verif/rx_ring_dequeue_control_unit_tb.sv
